### hw/rtl/imgnrm_pkg.sv
// Shared types, widths and helpers for the image point normalization block.
package imgnrm_pkg;

  localparam int unsigned MaxPointsDef = 32;

  localparam int unsigned CoordW   = 24;
  localparam int unsigned NormW    = 24;
  localparam int unsigned ScaleW   = 32;
  localparam int unsigned OffW     = 40;
  // datapath widths sized for sets of up to 64 points
  localparam int unsigned DevW     = 32;
  localparam int unsigned MagW     = 31;
  localparam int unsigned SqW      = 2 * MagW;
  localparam int unsigned QsumW    = 68;
  localparam int unsigned NumShift = 49;
  localparam int unsigned ProdW    = ScaleW + MagW;
  localparam int unsigned RdivW    = 64;
  localparam int unsigned RdenW    = 15;
  localparam int unsigned RdivStep = 4;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_t;

  typedef struct packed {
    logic signed [NormW-1:0] norm_x;
    logic signed [NormW-1:0] norm_y;
    logic [ScaleW-1:0]       scale;
    logic signed [OffW-1:0]  offset_x;
    logic signed [OffW-1:0]  offset_y;
    logic                    degenerate;
    logic                    overflowed;
    logic                    last_result;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd;
    logic dev;
    logic sq;
    logic acc;
    logic n2;
    logic n3;
    logic scl_start;
    logic mul;
    logic mul_off;
    logic div_start;
    logic off_save;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic scl_done;
    logic div_done;
    logic out_free;
  } sts_t;

  // signed saturation of a rounded magnitude to a field of 'bits' bits
  function automatic logic [OffW-1:0] sat_mag(input logic neg, input logic [RdivW-1:0] q,
                                              input int unsigned bits);
    logic [RdivW-1:0] lim;
    logic [RdivW-1:0] v;
    lim = RdivW'(1) << (bits - 1);
    if (neg) begin
      v = (q > lim) ? lim : q;
      v = RdivW'(0) - v;
    end else begin
      v = (q > lim - RdivW'(1)) ? lim - RdivW'(1) : q;
    end
    return v[OffW-1:0];
  endfunction

endpackage

### hw/rtl/imgnrm_rdiv.sv
// Floor divider: 64-bit dividend by a narrow divisor, four quotient bits per cycle.
module imgnrm_rdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [imgnrm_pkg::RdivW-1:0] dvd_i,
  input  logic [imgnrm_pkg::RdenW-1:0] den_i,
  output logic [imgnrm_pkg::RdivW-1:0] quo_o,
  output logic                        done_o
);
  import imgnrm_pkg::*;

  localparam int unsigned Steps = RdivW / RdivStep;
  localparam int unsigned StW   = $clog2(Steps);

  logic             busy_q, done_q;
  logic [StW-1:0]   cnt_q;
  logic [RdivW-1:0] dvd_q, dvd_d;
  logic [RdenW-1:0] rem_q, rem_d, den_q;

  always_comb begin
    logic [RdenW:0] t;
    logic           ge;
    rem_d = rem_q;
    dvd_d = dvd_q;
    for (int k = 0; k < RdivStep; k++) begin
      t     = {rem_d, dvd_d[RdivW-1]};
      ge    = t >= {1'b0, den_q};
      rem_d = ge ? RdenW'(t - {1'b0, den_q}) : t[RdenW-1:0];
      dvd_d = {dvd_d[RdivW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o  = dvd_q;
  assign done_o = done_q;

endmodule

### hw/rtl/imgnrm_scl.sv
// Scale unit: floor(sqrt(num / den)) by a bit-serial divide then a digit-serial root.
module imgnrm_scl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [imgnrm_pkg::QsumW-1:0]  num_i,
  input  logic [imgnrm_pkg::QsumW-1:0]  den_i,
  output logic [imgnrm_pkg::ScaleW-1:0] scale_o,
  output logic                         done_o
);
  import imgnrm_pkg::*;

  localparam int unsigned RootW = 2 * ScaleW;
  localparam int unsigned CntW  = $clog2(QsumW);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_ROOT} st_e;

  st_e               state_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q;
  logic [QsumW-1:0]  dvd_q, rem_q, den_q, dvd_d, rem_d;
  logic [RootW-1:0]  v_q, res_q, bit_q, v_d, res_d, trial;
  logic [ScaleW-1:0] scale_q;
  logic              ge;
  logic [QsumW:0]    rsh;

  always_comb begin
    rsh   = {rem_q, dvd_q[QsumW-1]};
    ge    = rsh >= {1'b0, den_q};
    rem_d = ge ? QsumW'(rsh - {1'b0, den_q}) : rsh[QsumW-1:0];
    dvd_d = {dvd_q[QsumW-2:0], ge};
    trial = res_q + bit_q;
    if (v_q >= trial) begin
      v_d   = v_q - trial;
      res_d = (res_q >> 1) + bit_q;
    end else begin
      v_d   = v_q;
      res_d = res_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cnt_q <= '0;
            if (den_i == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(QsumW - 1)) begin
            cnt_q <= '0;
            // quotient of 2^64 or more saturates the scale
            if (dvd_d[QsumW-1:RootW] != '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(ScaleW - 1)) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        dvd_q   <= num_i;
        rem_q   <= '0;
        den_q   <= den_i;
        scale_q <= '0;
      end
      S_DIV: begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
        v_q   <= dvd_d[RootW-1:0];
        res_q <= '0;
        bit_q <= RootW'(1) << (RootW - 2);
        if (cnt_q == CntW'(QsumW - 1) && dvd_d[QsumW-1:RootW] != '0) begin
          scale_q <= '1;
        end
      end
      S_ROOT: begin
        v_q     <= v_d;
        res_q   <= res_d;
        bit_q   <= bit_q >> 2;
        scale_q <= res_d[ScaleW-1:0];
      end
      default: ;
    endcase
  end

  assign scale_o = scale_q;
  assign done_o  = done_q;

endmodule

### hw/rtl/imgnrm_dp.sv
// Datapath: point store, sums, deviation and square arithmetic, dividers, output register.
module imgnrm_dp #(
  parameter int unsigned MAX_POINTS = imgnrm_pkg::MaxPointsDef,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imgnrm_pkg::cmd_t  cmd_i,
  input  logic [AW-1:0]     idx_i,
  input  imgnrm_pkg::in_t   in_i,
  output logic [CW-1:0]     n_o,
  output imgnrm_pkg::sts_t  sts_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output imgnrm_pkg::out_t  out_o
);
  import imgnrm_pkg::*;

  localparam int unsigned SW = CoordW + CW;

  logic [2*CoordW-1:0]     mem [MAX_POINTS];
  logic [2*CoordW-1:0]     rd_q;
  logic [CW-1:0]           cnt_q;
  logic signed [SW-1:0]    sx_q, sy_q;
  logic                    ovf_q;
  logic [QsumW-1:0]        q_q;
  logic signed [DevW-1:0]  dx_q, dy_q;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [2*CW-1:0]         nn_q;
  logic [3*CW-1:0]         n3_q;
  logic [ScaleW-1:0]       scale_q;
  logic                    degen_q;
  logic [ProdW-1:0]        mx_q, my_q;
  logic                    negx_q, negy_q;
  logic [OffW-1:0]         offx_q, offy_q;
  out_t                    out_q;
  logic                    out_valid_q;

  logic                    room;
  logic signed [DevW-1:0]  xe, ye, ne, sxe, sye, dx_d, dy_d;
  logic [MagW-1:0]         magx, magy, sxm, sym, max_in, may_in;
  logic [SqW-1:0]          sqx, sqy;
  logic [2*CW-1:0]         nn;
  logic [3*CW-1:0]         n3;
  logic [ProdW-1:0]        prx, pry;
  logic [RdivW-1:0]        ax, ay, quox, quoy;
  logic [RdenW-1:0]        den;
  logic                    donex, doney;
  logic [ScaleW-1:0]       scl_scale;
  logic                    scl_done;
  logic [OffW-1:0]         satx, saty, soffx, soffy;
  logic                    out_free;

  assign room = cnt_q < CW'(MAX_POINTS);

  always_comb begin
    xe   = DevW'(signed'(rd_q[2*CoordW-1:CoordW]));
    ye   = DevW'(signed'(rd_q[CoordW-1:0]));
    ne   = DevW'({1'b0, cnt_q});
    sxe  = DevW'(sx_q);
    sye  = DevW'(sy_q);
    dx_d = DevW'(xe * ne) - sxe;
    dy_d = DevW'(ye * ne) - sye;
    magx = dx_q[DevW-1] ? MagW'(-dx_q) : MagW'(dx_q);
    magy = dy_q[DevW-1] ? MagW'(-dy_q) : MagW'(dy_q);
    sxm  = sxe[DevW-1] ? MagW'(-sxe) : MagW'(sxe);
    sym  = sye[DevW-1] ? MagW'(-sye) : MagW'(sye);
    max_in = cmd_i.mul_off ? sxm : magx;
    may_in = cmd_i.mul_off ? sym : magy;
  end

  assign sqx = magx * magx;
  assign sqy = magy * magy;
  assign nn  = cnt_q * cnt_q;
  assign n3  = nn_q * cnt_q;
  assign prx = scale_q * max_in;
  assign pry = scale_q * may_in;
  // round half away: add half the divisor before the floor divide
  assign ax  = RdivW'(mx_q) + RdivW'({cnt_q, 7'b0});
  assign ay  = RdivW'(my_q) + RdivW'({cnt_q, 7'b0});
  assign den = RdenW'({cnt_q, 8'b0});

  always_comb begin
    satx  = sat_mag(negx_q, quox, NormW);
    saty  = sat_mag(negy_q, quoy, NormW);
    soffx = sat_mag(negx_q, quox, OffW);
    soffy = sat_mag(negy_q, quoy, OffW);
  end

  imgnrm_scl u_scl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.scl_start),
    .num_i   (QsumW'(n3_q) << NumShift),
    .den_i   (q_q),
    .scale_o (scl_scale),
    .done_o  (scl_done)
  );

  imgnrm_rdiv u_rdiv_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (ax),
    .den_i   (den),
    .quo_o   (quox),
    .done_o  (donex)
  );

  imgnrm_rdiv u_rdiv_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dvd_i   (ay),
    .den_i   (den),
    .quo_o   (quoy),
    .done_o  (doney)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem[cnt_q[AW-1:0]] <= {in_i.point_x, in_i.point_y};
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      ovf_q       <= 1'b0;
      q_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        ovf_q <= 1'b0;
        q_q   <= '0;
      end else if (cmd_i.load) begin
        if (room) begin
          cnt_q <= cnt_q + 1'b1;
          sx_q  <= sx_q + SW'(in_i.point_x);
          sy_q  <= sy_q + SW'(in_i.point_y);
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (cmd_i.acc) begin
        q_q <= q_q + QsumW'(sqx_q) + QsumW'(sqy_q);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dev) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (cmd_i.sq) begin
      sqx_q <= sqx;
      sqy_q <= sqy;
    end
    if (cmd_i.n2) nn_q <= nn;
    if (cmd_i.n3) n3_q <= n3;
    if (cmd_i.scl_start) degen_q <= (q_q == '0);
    if (scl_done) scale_q <= scl_scale;
    if (cmd_i.mul) begin
      mx_q   <= prx;
      my_q   <= pry;
      // offsets carry the opposite sign of the centroid
      negx_q <= cmd_i.mul_off ? (sxe > 0) : dx_q[DevW-1];
      negy_q <= cmd_i.mul_off ? (sye > 0) : dy_q[DevW-1];
    end
    if (cmd_i.off_save) begin
      offx_q <= soffx;
      offy_q <= soffy;
    end
    if (cmd_i.out_load) begin
      out_q.norm_x      <= satx[NormW-1:0];
      out_q.norm_y      <= saty[NormW-1:0];
      out_q.scale       <= scale_q;
      out_q.offset_x    <= offx_q;
      out_q.offset_y    <= offy_q;
      out_q.degenerate  <= degen_q;
      out_q.overflowed  <= ovf_q;
      out_q.last_result <= cmd_i.out_last;
    end
  end

  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.scl_done = scl_done;
  assign sts_o.div_done = donex && doney;
  assign sts_o.out_free = out_free;
  assign n_o            = cnt_q;
  assign out_valid_o    = out_valid_q;
  assign out_o          = out_q;

endmodule

### hw/rtl/imgnrm_ctrl.sv
// Controller: load, accumulate, scale, offset and emit sequencing.
module imgnrm_ctrl #(
  parameter int unsigned MAX_POINTS = imgnrm_pkg::MaxPointsDef,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_stall_o,
  input  logic [CW-1:0]    n_i,
  input  imgnrm_pkg::sts_t sts_i,
  output imgnrm_pkg::cmd_t cmd_o,
  output logic [AW-1:0]    idx_o
);
  import imgnrm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ARD, ST_ADEV, ST_ASQ, ST_AADD, ST_N2, ST_N3, ST_SGO, ST_SWAIT,
    ST_OMUL, ST_OGO, ST_OWAIT, ST_PRD, ST_PDEV, ST_PMUL, ST_PGO, ST_PWAIT, ST_POUT
  } st_e;

  st_e           state_q;
  logic [CW-1:0] idx_q;
  logic          accept, at_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign at_last    = idx_q == CW'(n_i - 1'b1);
  assign idx_o      = idx_q[AW-1:0];

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (state_q)
      ST_ARD, ST_PRD:   cmd_o.rd = 1'b1;
      ST_ADEV, ST_PDEV: cmd_o.dev = 1'b1;
      ST_ASQ:           cmd_o.sq = 1'b1;
      ST_AADD:          cmd_o.acc = 1'b1;
      ST_N2:            cmd_o.n2 = 1'b1;
      ST_N3:            cmd_o.n3 = 1'b1;
      ST_SGO:           cmd_o.scl_start = 1'b1;
      ST_OMUL: begin
        cmd_o.mul     = 1'b1;
        cmd_o.mul_off = 1'b1;
      end
      ST_PMUL:          cmd_o.mul = 1'b1;
      ST_OGO, ST_PGO:   cmd_o.div_start = 1'b1;
      ST_OWAIT:         cmd_o.off_save = sts_i.div_done;
      ST_POUT: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_last = at_last;
        cmd_o.clr      = sts_i.out_free && at_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (accept && in_last_i) state_q <= ST_ARD;
        end
        ST_ARD:  state_q <= ST_ADEV;
        ST_ADEV: state_q <= ST_ASQ;
        ST_ASQ:  state_q <= ST_AADD;
        ST_AADD: begin
          if (at_last) begin
            idx_q   <= '0;
            state_q <= ST_N2;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_ARD;
          end
        end
        ST_N2:   state_q <= ST_N3;
        ST_N3:   state_q <= ST_SGO;
        ST_SGO:  state_q <= ST_SWAIT;
        ST_SWAIT: if (sts_i.scl_done) state_q <= ST_OMUL;
        ST_OMUL: state_q <= ST_OGO;
        ST_OGO:  state_q <= ST_OWAIT;
        ST_OWAIT: if (sts_i.div_done) state_q <= ST_PRD;
        ST_PRD:  state_q <= ST_PDEV;
        ST_PDEV: state_q <= ST_PMUL;
        ST_PMUL: state_q <= ST_PGO;
        ST_PGO:  state_q <= ST_PWAIT;
        ST_PWAIT: if (sts_i.div_done) state_q <= ST_POUT;
        ST_POUT: begin
          if (sts_i.out_free) begin
            if (at_last) begin
              idx_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= ST_PRD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && in_last_i) |=> in_stall_o)
    else $error("input not stalled after closing beat");

  a_clr_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr |-> (cmd_o.out_load && cmd_o.out_last))
    else $error("set cleared before its last result");

  a_rd_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |-> (idx_q < n_i))
    else $error("read beyond stored points");

endmodule

### hw/rtl/image_point_normalization.sv
// Top level: isotropic normalization of a set of 2D points.
//
// Input beats carry one point (signed Q16.8) each; the beat with last_point
// set closes the set. Points past MAX_POINTS are dropped and flag overflowed.
// A beat is taken whenever in_stall_o is low. After the closing beat in_stall_o
// stays high until the last result has been loaded into the output register.
// Work after the closing beat, in order:
//   one pass over the point memory to sum squared deviations (read,
//   deviation, square and add for each point), the scale unit (bit-serial
//   divide, then a root; both skipped for a degenerate set), the offsets,
//   then for each result the rounding divide (four quotient bits a cycle)
//   and the load of the output register.
// Results leave in load order, one per output beat; last_result marks the
// final one. A stalled output beat holds in the output register and the
// emit sequence waits for it. Reset empties the set and the output register;
// the point memory is not cleared and needs no clearing pass.
module image_point_normalization #(
  parameter int unsigned MAX_POINTS = imgnrm_pkg::MaxPointsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  imgnrm_pkg::in_t  in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output imgnrm_pkg::out_t out_o
);
  import imgnrm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] n;
  logic [AW-1:0] idx;

  imgnrm_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_i.last_point),
    .in_stall_o (in_stall_o),
    .n_i        (n),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  imgnrm_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .in_i        (in_i),
    .n_o         (n),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

### tb/tb_image_point_normalization.sv
// Testbench for image_point_normalization: point sets against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_image_point_normalization;
  import imgnrm_pkg::*;

  localparam int unsigned NPTS = 32;
  localparam int unsigned NUM_ITEMS = 380;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_o;

  image_point_normalization #(.MAX_POINTS(NPTS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_o(out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("image_point_normalization verification failed");
    $finish;
  end

  // predictor state: the set being loaded
  longint pt_x[NPTS];
  longint pt_y[NPTS];
  int     pt_cnt;
  longint acc_x, acc_y;
  bit     drop_seen;
  out_t   norm_q[$];
  int     err_cnt = 0;
  bit     hold_req = 1'b0;
  int     idle_max = 10;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // round-to-nearest (ties away), signed saturate to 'bits'
  function automatic logic [OffW-1:0] round_sat(bit neg, logic [127:0] mag,
                                                logic [127:0] den, int bits);
    logic [127:0] q, lim, v;
    q = (mag + den / 2) / den;
    lim = 128'd1 << (bits - 1);
    if (neg) begin
      if (q > lim) q = lim;
      v = 128'd0 - q;
    end else begin
      if (q > lim - 1) q = lim - 1;
      v = q;
    end
    return v[OffW-1:0];
  endfunction

  function automatic logic [127:0] absval(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  // closes the set: queue one normalized point per stored point
  task automatic normalize_set();
    logic [127:0] qsum, num, quo, den;
    logic [63:0]  s;
    longint       dx, dy;
    out_t         r;
    qsum = '0;
    s = '0;
    for (int i = 0; i < pt_cnt; i++) begin
      dx = pt_cnt * pt_x[i] - acc_x;
      dy = pt_cnt * pt_y[i] - acc_y;
      qsum += absval(dx) * absval(dx) + absval(dy) * absval(dy);
    end
    if (qsum != 0) begin
      num = 128'(pt_cnt) * pt_cnt * pt_cnt;
      num = num << NumShift;
      quo = num / qsum;
      if (quo[127:64] != 0) s = 64'hFFFF_FFFF;
      else begin
        s = root64(quo[63:0]);
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      end
    end
    den = 128'(256 * pt_cnt);
    for (int i = 0; i < pt_cnt; i++) begin
      dx = pt_cnt * pt_x[i] - acc_x;
      dy = pt_cnt * pt_y[i] - acc_y;
      r.norm_x      = NormW'(round_sat(dx < 0, s * absval(dx), den, NormW));
      r.norm_y      = NormW'(round_sat(dy < 0, s * absval(dy), den, NormW));
      r.scale       = s[ScaleW-1:0];
      r.offset_x    = round_sat(acc_x > 0, s * absval(acc_x), den, OffW);
      r.offset_y    = round_sat(acc_y > 0, s * absval(acc_y), den, OffW);
      r.degenerate  = (qsum == 0);
      r.overflowed  = drop_seen;
      r.last_result = (i == pt_cnt - 1);
      norm_q.push_back(r);
    end
    pt_cnt = 0;
    acc_x = 0;
    acc_y = 0;
    drop_seen = 0;
  endtask

  task automatic load_point(in_t p);
    if (pt_cnt < NPTS) begin
      pt_x[pt_cnt] = longint'(p.point_x);
      pt_y[pt_cnt] = longint'(p.point_y);
      pt_cnt++;
      acc_x += longint'(p.point_x);
      acc_y += longint'(p.point_y);
    end else begin
      drop_seen = 1;
    end
  endtask

  // drive one beat, wait for it to be taken, then idle for a random gap (possibly none)
  task automatic send_point(in_t p);
    int gap;
    @(negedge clk_i);
    in_i = p;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // output check
  always @(posedge clk_i) begin
    out_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (norm_q.size() == 0) begin
        report("unexpected beat", 64'(out_o.norm_x), 64'(0));
      end else begin
        w = norm_q.pop_front();
        if (out_o.norm_x !== w.norm_x)
          report("norm_x", 64'(out_o.norm_x), 64'(w.norm_x));
        if (out_o.norm_y !== w.norm_y)
          report("norm_y", 64'(out_o.norm_y), 64'(w.norm_y));
        if (out_o.scale !== w.scale)
          report("scale", 64'(out_o.scale), 64'(w.scale));
        if (out_o.offset_x !== w.offset_x)
          report("offset_x", 64'(out_o.offset_x), 64'(w.offset_x));
        if (out_o.offset_y !== w.offset_y)
          report("offset_y", 64'(out_o.offset_y), 64'(w.offset_y));
        if (out_o.degenerate !== w.degenerate)
          report("degenerate", 64'(out_o.degenerate), 64'(w.degenerate));
        if (out_o.overflowed !== w.overflowed)
          report("overflowed", 64'(out_o.overflowed), 64'(w.overflowed));
        if (out_o.last_result !== w.last_result)
          report("last_result", 64'(out_o.last_result), 64'(w.last_result));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        n = $urandom_range(0, idle_max);
        if (n > 0) begin
          @(negedge clk_i);
          out_stall_i = 1'b1;
          repeat (n - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  typedef struct {
    int   x, y;
    bit   last;
    bit   typed;
    out_t want;
  } vec_t;

  localparam int XMAX = 8388607;
  localparam int XMIN = -8388608;

  function automatic out_t lone_point();
    out_t r;
    r = '0;
    r.degenerate = 1'b1;
    r.last_result = 1'b1;
    return r;
  endfunction

  function automatic int coord(int mode, int base);
    case (mode)
      0: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      1: return ($urandom_range(0, 1) != 0) ? XMAX : XMIN;
      2: return base + $urandom_range(0, 1);
      3: return base;
      default: return base + $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  initial begin
    vec_t   dir_tab[$];
    in_t    p;
    int     sent, set_idx, sz, mode, bx, by, r;
    pt_cnt = 0;
    acc_x = 0;
    acc_y = 0;
    drop_seen = 0;
    dir_tab = '{
      '{0, 0, 1, 1, lone_point()},
      '{XMAX, XMAX, 1, 1, lone_point()},
      '{XMIN, XMIN, 1, 1, lone_point()},
      '{XMIN, XMIN, 0, 0, '0}, '{XMAX, XMAX, 1, 0, '0},
      '{XMAX, XMIN, 0, 0, '0}, '{XMIN, XMAX, 0, 0, '0},
      '{0, 0, 0, 0, '0}, '{1, -1, 1, 0, '0},
      '{7, 7, 0, 0, '0}, '{7, 7, 1, 0, '0},
      '{100, 200, 0, 0, '0}, '{101, 200, 1, 0, '0},
      '{XMAX, 0, 0, 0, '0}, '{XMAX, 0, 0, 0, '0}, '{XMAX, 1, 1, 0, '0},
      '{-5000, 3000, 0, 0, '0}, '{12345, -678, 0, 0, '0},
      '{-1, 1, 0, 0, '0}, '{400000, -400000, 1, 0, '0}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sent = 0;
    foreach (dir_tab[i]) begin
      p.point_x = dir_tab[i].x[CoordW-1:0];
      p.point_y = dir_tab[i].y[CoordW-1:0];
      p.last_point = dir_tab[i].last;
      send_point(p);
      load_point(p);
      if (p.last_point) begin
        if (dir_tab[i].typed) begin
          norm_q.push_back(dir_tab[i].want);
          pt_cnt = 0; acc_x = 0; acc_y = 0; drop_seen = 0;
        end else begin
          normalize_set();
        end
      end
      sent++;
    end

    set_idx = 0;
    while (sent < NUM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 6) sz = $urandom_range(1, 8);
      else if (r < 8) sz = $urandom_range(9, NPTS);
      else if (r == 8) sz = $urandom_range(NPTS + 1, NPTS + 4);
      else sz = ($urandom_range(0, 1) != 0) ? NPTS : 1;
      mode = $urandom_range(0, 4);
      bx = coord(0, 0);
      by = coord(0, 0);
      if (mode >= 2) begin
        bx = bx / 2;
        by = by / 2;
      end
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      if (set_idx == 3) hold_req = 1'b1;
      if (set_idx == 6) wait (norm_q.size() == 0);
      for (int k = 0; k < sz; k++) begin
        p.point_x = CoordW'(coord(mode, bx));
        p.point_y = CoordW'(coord(mode, by));
        p.last_point = (k == sz - 1);
        send_point(p);
        load_point(p);
        if (p.last_point) normalize_set();
        sent++;
      end
      set_idx++;
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (norm_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("image_point_normalization verification clean");
    end else begin
      $display("image_point_normalization verification failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/imgnrm_pkg.sv
hw/rtl/imgnrm_rdiv.sv
hw/rtl/imgnrm_scl.sv
hw/rtl/imgnrm_dp.sv
hw/rtl/imgnrm_ctrl.sv
hw/rtl/image_point_normalization.sv
tb/tb_image_point_normalization.sv
